/* src/weather_report_frame_builder_assert.svh */
// assertion macros for the weather report frame builder
`ifndef WEATHER_REPORT_FRAME_BUILDER_ASSERT_SVH
`define WEATHER_REPORT_FRAME_BUILDER_ASSERT_SVH

`ifndef SYNTHESIS

// checked on every rising clock edge outside reset
`define WRFB_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("wrfb assertion failed");

// implication form, checked outside reset
`define WRFB_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("wrfb implication failed");

`else

`define WRFB_ASSERT(name, prop)
`define WRFB_ASSERT_IMPL(name, pre, post)

`endif

`endif

/* src/wrfb_pkg.sv */
package wrfb_pkg;

  localparam int FRAME_BYTES = 32;
  localparam int POS_W       = $clog2(FRAME_BYTES);

  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_INIT  = 16'hffff;
  localparam logic [15:0] SIGN_FLAG = 16'h8000;
  localparam logic [15:0] TEMP_MIN  = 16'h8000;
  localparam logic [14:0] MAG_MAX   = 15'h7fff;

  // fixed header bytes
  localparam logic [7:0] HDR_B0   = 8'h1c;
  localparam logic [7:0] HDR_B1   = 8'h02;
  localparam logic [7:0] HDR_B5   = 8'h0d;
  localparam logic [7:0] HDR_B8   = 8'ha5;
  localparam logic [7:0] HDR_B9   = 8'hfe;
  localparam logic [7:0] HDR_B11  = 8'h08;
  localparam logic [7:0] BYTE_MASK = 8'hff;

  // frame offsets
  localparam int OFS_HDR0   = 0;
  localparam int OFS_HDR1   = 1;
  localparam int OFS_HDR5   = 5;
  localparam int OFS_CRC_LO = 6;
  localparam int OFS_CRC_HI = 7;
  localparam int OFS_HDR8   = 8;
  localparam int OFS_HDR9   = 9;
  localparam int OFS_HDR11  = 11;
  localparam int OFS_SYM    = 13;
  localparam int OFS_NOW_HI = 14;
  localparam int OFS_NOW_LO = 15;
  localparam int OFS_HI_HI  = 16;
  localparam int OFS_HI_LO  = 17;
  localparam int OFS_LO_HI  = 18;
  localparam int OFS_LO_LO  = 19;
  localparam int OFS_CSUM   = 20;
  localparam int SUM_FROM   = 9;

  // queue between front and back, depth kept a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic        [7:0]  weather_symbol;
    logic signed [15:0] temp_now;
    logic signed [15:0] temp_high;
    logic signed [15:0] temp_low;
  } wrfb_in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } wrfb_out_t;

  // record after temperature encoding
  typedef struct packed {
    logic [7:0]  symbol;
    logic [15:0] enc_now;
    logic [15:0] enc_high;
    logic [15:0] enc_low;
  } wrfb_rec_t;

  typedef struct packed {
    logic empty;
    logic full;
  } wrfb_q_stat_t;

  typedef struct packed {
    logic pop;
    logic emitting;
  } wrfb_bk_stat_t;

  // two's complement to sign-magnitude, -32768 saturates to -32767
  function automatic logic [15:0] encode_temp(logic [15:0] v);
    logic [15:0] neg;
    logic [14:0] mag;
    neg = 16'(~v + 16'd1);
    if (!v[15]) begin
      return v;
    end
    mag = (v == TEMP_MIN) ? MAG_MAX : neg[14:0];
    return SIGN_FLAG | {1'b0, mag};
  endfunction

  // one byte of crc-16/ccitt-false, msb first
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // frame byte at a position; crc and checksum only when the frame is final
  function automatic logic [7:0] frame_byte_at(wrfb_rec_t rec, logic [POS_W-1:0] pos,
                                               logic [15:0] crc, logic [7:0] csum,
                                               logic fin);
    logic [7:0] b;
    unique case (pos)
      POS_W'(OFS_HDR0):   b = HDR_B0;
      POS_W'(OFS_HDR1):   b = HDR_B1;
      POS_W'(OFS_HDR5):   b = HDR_B5;
      POS_W'(OFS_CRC_LO): b = fin ? crc[7:0] : 8'h00;
      POS_W'(OFS_CRC_HI): b = fin ? crc[15:8] : 8'h00;
      POS_W'(OFS_HDR8):   b = HDR_B8;
      POS_W'(OFS_HDR9):   b = HDR_B9;
      POS_W'(OFS_HDR11):  b = HDR_B11;
      POS_W'(OFS_SYM):    b = rec.symbol;
      POS_W'(OFS_NOW_HI): b = rec.enc_now[15:8];
      POS_W'(OFS_NOW_LO): b = rec.enc_now[7:0];
      POS_W'(OFS_HI_HI):  b = rec.enc_high[15:8];
      POS_W'(OFS_HI_LO):  b = rec.enc_high[7:0];
      POS_W'(OFS_LO_HI):  b = rec.enc_low[15:8];
      POS_W'(OFS_LO_LO):  b = rec.enc_low[7:0];
      POS_W'(OFS_CSUM):   b = fin ? csum : 8'h00;
      default:            b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* src/weather_report_frame_builder.sv */
// Weather report frame builder: each accepted transaction on the input channel
// (symbol code and three signed temperatures) yields one report frame of
// FRAME_BYTES bytes on the output channel, one byte per transaction, with
// frame_last set on the final byte. Temperatures go out as big-endian
// sign-magnitude, -32768 saturating to -32767. The frame carries a
// CRC-16/CCITT-FALSE (low byte first at offsets 6 and 7) and an inverted byte
// sum at offset 20. Each frame takes two passes over its FRAME_BYTES bytes,
// first through the byte-serial CRC unit, then through the single output
// register, after which the back end returns to idle to take the next record.
// Up to three further records wait in the input stage and the two-entry queue
// while a frame is being built or sent.
`include "weather_report_frame_builder_assert.svh"

module weather_report_frame_builder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wrfb_pkg::wrfb_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wrfb_pkg::wrfb_out_t out_data_o
);
  import wrfb_pkg::*;

  logic          push_valid, push_ready;
  wrfb_rec_t     push_data, pop_data;
  wrfb_q_stat_t  q_stat;
  wrfb_bk_stat_t bk_stat;

  wrfb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  wrfb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_i        (bk_stat.pop),
    .pop_data_o   (pop_data),
    .stat_o       (q_stat)
  );

  wrfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_avail_i   (!q_stat.empty),
    .q_data_i    (pop_data),
    .stat_o      (bk_stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // queue cannot be empty and full at once
  `WRFB_ASSERT(a_queue_sane, !(q_stat.empty && q_stat.full))
  // back end only takes a record that is there
  `WRFB_ASSERT_IMPL(a_pop_nonempty, bk_stat.pop, !q_stat.empty)
  // a new record is taken only between frames
  `WRFB_ASSERT_IMPL(a_pop_not_emitting, bk_stat.pop, !bk_stat.emitting)
  // a waiting output transaction holds its payload
  `WRFB_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))

endmodule

/* src/wrfb_front.sv */
module wrfb_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  wrfb_pkg::wrfb_in_t   in_data_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output wrfb_pkg::wrfb_rec_t  push_data_o
);
  import wrfb_pkg::*;

  logic      vld_q, vld_d;
  wrfb_rec_t rec_q;
  logic      take;

  assign in_ready_o   = !vld_q || push_ready_i;
  assign take         = in_valid_i && in_ready_o;
  assign push_valid_o = vld_q;
  assign push_data_o  = rec_q;

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (push_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      rec_q.symbol   <= in_data_i.weather_symbol;
      rec_q.enc_now  <= encode_temp(in_data_i.temp_now);
      rec_q.enc_high <= encode_temp(in_data_i.temp_high);
      rec_q.enc_low  <= encode_temp(in_data_i.temp_low);
    end
  end

endmodule

/* src/wrfb_queue.sv */
module wrfb_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_valid_i,
  output logic                   push_ready_o,
  input  wrfb_pkg::wrfb_rec_t    push_data_i,
  input  logic                   pop_i,
  output wrfb_pkg::wrfb_rec_t    pop_data_o,
  output wrfb_pkg::wrfb_q_stat_t stat_o
);
  import wrfb_pkg::*;

  wrfb_rec_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign push_ready_o = !stat_o.full;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && !stat_o.empty;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* src/wrfb_back.sv */
module wrfb_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_avail_i,
  input  wrfb_pkg::wrfb_rec_t     q_data_i,
  output wrfb_pkg::wrfb_bk_stat_t stat_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output wrfb_pkg::wrfb_out_t     out_data_o
);
  import wrfb_pkg::*;

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_CRC  = 3'b010,
    BK_EMIT = 3'b100
  } bk_state_e;

  bk_state_e        state_q, state_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       sum_q, sum_d;
  wrfb_rec_t        rec_q, rec_d;
  logic             out_vld_q, out_vld_d;
  wrfb_out_t        out_q;
  logic             pop, out_load, at_last;
  logic [7:0]       cur_byte;

  assign at_last  = (pos_q == POS_W'(FRAME_BYTES - 1));
  assign cur_byte = frame_byte_at(rec_q, pos_q, crc_q, sum_q ^ BYTE_MASK,
                                  state_q == BK_EMIT);

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    crc_d    = crc_q;
    sum_d    = sum_q;
    rec_d    = rec_q;
    pop      = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (q_avail_i) begin
          pop     = 1'b1;
          rec_d   = q_data_i;
          crc_d   = CRC_INIT;
          sum_d   = '0;
          pos_d   = '0;
          state_d = BK_CRC;
        end
      end
      BK_CRC: begin
        // crc and checksum slots read as zero in this pass
        crc_d = crc_byte(crc_q, cur_byte);
        if (pos_q >= POS_W'(SUM_FROM)) begin
          sum_d = sum_q + cur_byte;
        end
        if (at_last) begin
          pos_d   = '0;
          state_d = BK_EMIT;
        end else begin
          pos_d = pos_q + POS_W'(1);
        end
      end
      BK_EMIT: begin
        if (!out_vld_q || out_ready_i) begin
          out_load = 1'b1;
          if (at_last) begin
            pos_d   = '0;
            state_d = BK_IDLE;
          end else begin
            pos_d = pos_q + POS_W'(1);
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      pos_q     <= '0;
      crc_q     <= CRC_INIT;
      sum_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      crc_q     <= crc_d;
      sum_q     <= sum_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
    if (out_load) begin
      out_q.frame_byte <= cur_byte;
      out_q.frame_last <= at_last;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign out_data_o      = out_q;
  assign stat_o.pop      = pop;
  assign stat_o.emitting = (state_q == BK_EMIT);

endmodule
